### src/dmac_pkg.sv
`default_nettype none
package dmac_pkg;
    localparam int NUM_CHANNELS = 7;
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [31:0] GPU_PORT  = 32'h1F801810;
    localparam logic [23:0] LIST_END  = 24'hffffff;
    localparam logic [31:0] DPCR_INIT = 32'h07654321;
    localparam logic [6:0] OFF_DPCR = 7'h70;
    localparam logic [6:0] OFF_DICR = 7'h74;
    localparam logic [3:0] REG_MADR = 4'h0;
    localparam logic [3:0] REG_BCR  = 4'h4;
    localparam logic [3:0] REG_CHCR = 4'h8;

    typedef enum logic [2:0] {
        PH_IDLE, PH_OTC, PH_BLK_RD, PH_BLK_WR,
        PH_LST_HDR, PH_LST_HDRDATA, PH_LST_PKT, PH_LST_PKTRD
    } t_phase;

    // controller to datapath
    typedef struct packed {
        logic       start_otc;
        logic       start_blk;
        logic       start_lst;
        logic       otc_step;
        logic       blk_read;
        logic       blk_write;
        logic       blk_reload;
        logic       hdr_issue;
        logic       hdr_data;
        logic       pkt_write;
        logic       pkt_read;
        logic       link_store;
        logic       finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       busy;
        logic       trig;
        logic       from_ram;
        logic       bcr_empty;
        logic       otc_last;
        logic       blk_word_last;
        logic       blk_block_last;
        logic       reload_empty;
        logic       hdr_has_pkt;
        logic       link_end;
        logic       pkt_last;
        logic       chan_ok;
    } t_stat;
endpackage
`default_nettype wire

### src/dmac_ctrl.sv
`default_nettype none
module dmac_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [1:0]    i_operation,
    input  wire logic          i_chcr_wr,
    input  wire logic [2:0]    i_ch,
    input  wire dmac_pkg::t_stat i_stat,
    output dmac_pkg::t_cmd     o_cmd
);
    import dmac_pkg::*;
    t_phase r_phase, n_phase;
    logic tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_phase <= PH_IDLE;
        else r_phase <= n_phase;
    end

    assign tick = i_start && (i_operation == OP_TICK);

    always_comb begin
        n_phase = r_phase;
        o_cmd = '0;
        if (i_chcr_wr && r_phase == PH_IDLE) begin
            if (i_stat.mode == 2'd0 && i_stat.busy && i_stat.trig) begin
                if (i_ch == 3'd6) begin
                    o_cmd.start_otc = 1'b1;
                    n_phase = PH_OTC;
                end
            end else if (i_stat.mode == 2'd2 && i_stat.busy) begin
                if (i_stat.from_ram) begin
                    o_cmd.start_lst = 1'b1;
                    n_phase = PH_LST_HDR;
                end
            end else if (i_stat.mode == 2'd1 && i_stat.busy) begin
                if (i_stat.from_ram) begin
                    o_cmd.start_blk = 1'b1;
                    if (i_stat.bcr_empty) o_cmd.finish = 1'b1;
                    else n_phase = PH_BLK_RD;
                end
            end
        end else if (tick) begin
            if (r_phase == PH_IDLE || !i_stat.chan_ok) begin
                n_phase = PH_IDLE;
            end else begin
                case (r_phase)
                    PH_OTC: begin
                        o_cmd.otc_step = 1'b1;
                        if (i_stat.otc_last) begin
                            o_cmd.finish = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_BLK_RD: begin
                        o_cmd.blk_read = 1'b1;
                        n_phase = PH_BLK_WR;
                    end
                    PH_BLK_WR: begin
                        o_cmd.blk_write = 1'b1;
                        n_phase = PH_BLK_RD;
                        if (i_stat.blk_word_last) begin
                            if (i_stat.blk_block_last || i_stat.reload_empty) begin
                                o_cmd.finish = 1'b1;
                                n_phase = PH_IDLE;
                            end else begin
                                o_cmd.blk_reload = 1'b1;
                            end
                        end
                    end
                    PH_LST_HDR: begin
                        o_cmd.hdr_issue = 1'b1;
                        n_phase = PH_LST_HDRDATA;
                    end
                    PH_LST_HDRDATA: begin
                        o_cmd.hdr_data = 1'b1;
                        if (i_stat.hdr_has_pkt) n_phase = PH_LST_PKT;
                        else if (i_stat.link_end) begin
                            o_cmd.finish = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_LST_PKT: begin
                        o_cmd.pkt_write = 1'b1;
                        if (!i_stat.pkt_last) n_phase = PH_LST_PKTRD;
                        else begin
                            o_cmd.link_store = 1'b1;
                            if (i_stat.link_end) begin
                                o_cmd.finish = 1'b1;
                                n_phase = PH_IDLE;
                            end else n_phase = PH_LST_HDR;
                        end
                    end
                    default: begin
                        o_cmd.pkt_read = 1'b1;
                        n_phase = PH_LST_PKT;
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

### src/dmac_datapath.sv
`default_nettype none
module dmac_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [1:0]    i_operation,
    input  wire logic [6:0]    i_bus_offset,
    input  wire logic [31:0]   i_write_data,
    input  wire logic [31:0]   i_mem_read_data,
    input  wire dmac_pkg::t_cmd i_cmd,
    output dmac_pkg::t_stat    o_stat,
    output logic               o_chcr_wr,
    output logic [2:0]         o_ch,
    output logic               o_strobe,
    output logic [31:0]        o_read_data,
    output logic [1:0]         o_mem_request,
    output logic [31:0]        o_mem_address,
    output logic [31:0]        o_mem_write_data,
    output logic               o_done_flag,
    output logic [2:0]         o_done_channel
);
    import dmac_pkg::*;
    logic [31:0] r_madr [NUM_CHANNELS];
    logic [31:0] r_bcr  [NUM_CHANNELS];
    logic [31:0] r_chcr [NUM_CHANNELS];
    logic [31:0] r_dpcr, r_dicr;
    logic [2:0]  r_act;
    logic [31:0] r_walk;
    logic [15:0] r_wcnt, r_bcnt;
    logic [7:0]  r_pkt;
    logic [23:0] r_link;

    logic [2:0] ch;
    logic [3:0] rg;
    logic       ch_ok, wr, rd;
    logic [31:0] chcr_now, bcr_a, madr_a, rdata;
    logic [15:0] wdec, bdec;
    logic [7:0]  pkt_dec;
    logic [31:0] walk4;
    logic [1:0]  req;
    logic [31:0] addr, wdat;

    assign ch = i_bus_offset[6:4];
    assign rg = i_bus_offset[3:0];
    assign ch_ok = 32'(ch) < NUM_CHANNELS;
    assign wr = i_start && i_operation == OP_WRITE;
    assign rd = i_start && i_operation == OP_READ;
    assign o_chcr_wr = wr && i_bus_offset != OFF_DPCR && i_bus_offset != OFF_DICR
                       && ch_ok && rg == REG_CHCR;
    assign o_ch = ch;
    assign chcr_now = i_write_data;
    assign bcr_a = r_bcr[r_act];
    assign madr_a = r_madr[r_act];
    assign wdec = r_wcnt - 16'd1;
    assign bdec = r_bcnt - 16'd1;
    assign pkt_dec = r_pkt - 8'd1;
    assign walk4 = r_walk + 32'd4;

    always_comb begin
        o_stat.mode = chcr_now[10:9];
        o_stat.busy = chcr_now[24];
        o_stat.trig = chcr_now[28];
        o_stat.from_ram = chcr_now[0];
        o_stat.bcr_empty = r_bcr[ch][31:16] == 16'd0 || r_bcr[ch][15:0] == 16'd0;
        o_stat.otc_last = r_wcnt <= 16'd1;
        o_stat.blk_word_last = wdec == 16'd0;
        o_stat.blk_block_last = bdec == 16'd0;
        o_stat.reload_empty = bcr_a[15:0] == 16'd0;
        o_stat.hdr_has_pkt = i_mem_read_data[31:24] != 8'd0;
        o_stat.link_end = i_cmd.hdr_data ? (i_mem_read_data[23:0] == LIST_END)
                                         : (r_link == LIST_END);
        o_stat.pkt_last = pkt_dec == 8'd0;
        o_stat.chan_ok = 32'(r_act) < NUM_CHANNELS;
    end

    always_comb begin
        rdata = '0;
        if (rd) begin
            if (i_bus_offset == OFF_DPCR) rdata = r_dpcr;
            else if (i_bus_offset == OFF_DICR) rdata = r_dicr;
            else if (ch_ok) begin
                case (rg)
                    REG_MADR: rdata = r_madr[ch];
                    REG_BCR:  rdata = r_bcr[ch];
                    REG_CHCR: rdata = r_chcr[ch];
                    default:  rdata = '0;
                endcase
            end
        end
        req = REQ_NONE;
        addr = '0;
        wdat = '0;
        if (i_cmd.otc_step) begin
            req = REQ_WRITE;
            addr = r_walk;
            wdat = o_stat.otc_last ? {8'd0, LIST_END} : r_walk - 32'd4;
        end
        if (i_cmd.blk_read) begin
            req = REQ_READ;
            addr = madr_a;
        end
        if (i_cmd.blk_write) begin
            req = REQ_WRITE;
            addr = (r_act == 3'd2) ? GPU_PORT : 32'd0;
            wdat = i_mem_read_data;
        end
        if (i_cmd.hdr_issue) begin
            req = REQ_READ;
            addr = madr_a;
        end
        if (i_cmd.hdr_data && !(o_stat.link_end && !o_stat.hdr_has_pkt)) begin
            req = REQ_READ;
            addr = o_stat.hdr_has_pkt ? walk4 : {8'd0, i_mem_read_data[23:0]};
        end
        if (i_cmd.pkt_write) begin
            req = REQ_WRITE;
            addr = GPU_PORT;
            wdat = i_mem_read_data;
        end
        if (i_cmd.pkt_read) begin
            req = REQ_READ;
            addr = walk4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_madr[i] <= '0;
                r_bcr[i]  <= '0;
                r_chcr[i] <= '0;
            end
            r_dpcr <= DPCR_INIT;
            r_dicr <= '0;
            r_act <= '0;
            r_walk <= '0;
            r_wcnt <= '0;
            r_bcnt <= '0;
            r_pkt <= '0;
            r_link <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_start;
            if (wr) begin
                if (i_bus_offset == OFF_DPCR) r_dpcr <= i_write_data;
                else if (i_bus_offset == OFF_DICR)
                    r_dicr <= i_write_data & ~32'h7fc0 & ~32'h7f000000;
                else if (ch_ok) begin
                    case (rg)
                        REG_MADR: r_madr[ch] <= i_write_data;
                        REG_BCR:  r_bcr[ch] <= i_write_data;
                        REG_CHCR: r_chcr[ch] <= i_write_data;
                        default: ;
                    endcase
                end
            end
            if (i_cmd.start_otc || i_cmd.start_blk || i_cmd.start_lst)
                r_act <= ch;
            if (i_cmd.start_otc) begin
                r_walk <= {8'd0, r_madr[ch][23:0]};
                r_wcnt <= r_bcr[ch][15:0];
            end
            if (i_cmd.start_blk) begin
                r_bcnt <= r_bcr[ch][31:16];
                r_wcnt <= r_bcr[ch][15:0];
            end
            if (i_cmd.otc_step && !o_stat.otc_last) begin
                r_walk <= r_walk - 32'd4;
                r_wcnt <= wdec;
            end
            if (i_cmd.blk_write) begin
                r_madr[r_act] <= madr_a + 32'd4;
                r_wcnt <= wdec;
                if (o_stat.blk_word_last) begin
                    r_bcnt <= bdec;
                    if (!o_stat.blk_block_last) r_wcnt <= bcr_a[15:0];
                end
            end
            if (i_cmd.hdr_issue) r_walk <= madr_a;
            if (i_cmd.hdr_data) begin
                r_pkt <= i_mem_read_data[31:24];
                r_link <= i_mem_read_data[23:0];
                if (o_stat.hdr_has_pkt) r_walk <= walk4;
                else begin
                    r_madr[r_act] <= {8'd0, i_mem_read_data[23:0]};
                    r_walk <= {8'd0, i_mem_read_data[23:0]};
                end
            end
            if (i_cmd.pkt_write) r_pkt <= pkt_dec;
            if (i_cmd.link_store) r_madr[r_act] <= {8'd0, r_link};
            if (i_cmd.pkt_read) r_walk <= walk4;
            if (i_cmd.finish) begin
                if (i_cmd.start_blk) r_chcr[ch] <= i_write_data & ~32'h11000000;
                else r_chcr[r_act] <= r_chcr[r_act] & ~32'h11000000;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_read_data <= rdata;
        o_mem_request <= req;
        o_mem_address <= addr;
        o_mem_write_data <= wdat;
        o_done_flag <= i_cmd.finish;
        o_done_channel <= i_cmd.finish ? (i_cmd.start_blk ? ch : r_act) : 3'd0;
    end
endmodule
`default_nettype wire

### src/dma_controller_three_sync_modes.sv
`default_nettype none
// Seven-channel DMA controller. Every word (bus read, bus write or engine
// tick) is taken at once: busy stays low and start may be high every
// cycle. The result shows on the outputs in the next cycle for one cycle,
// marked by o_valid; the receiver cannot stall it. At most one memory request a tick.
module dma_controller_three_sync_modes (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [6:0]  i_bus_offset,
    input  wire logic [31:0] i_write_data,
    input  wire logic [31:0] i_mem_read_data,
    output logic             o_valid,
    output logic [31:0]      o_read_data,
    output logic [1:0]       o_mem_request,
    output logic [31:0]      o_mem_address,
    output logic [31:0]      o_mem_write_data,
    output logic             o_done_flag,
    output logic [2:0]       o_done_channel
);
    import dmac_pkg::*;
    t_cmd cmd;
    t_stat stat;
    logic chcr_wr;
    logic [2:0] ch;

    assign busy = 1'b0;

    dmac_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_operation(i_operation), .i_chcr_wr(chcr_wr), .i_ch(ch),
        .i_stat(stat), .o_cmd(cmd)
    );

    dmac_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_operation(i_operation), .i_bus_offset(i_bus_offset),
        .i_write_data(i_write_data), .i_mem_read_data(i_mem_read_data),
        .i_cmd(cmd), .o_stat(stat), .o_chcr_wr(chcr_wr), .o_ch(ch),
        .o_strobe(o_valid), .o_read_data(o_read_data),
        .o_mem_request(o_mem_request), .o_mem_address(o_mem_address),
        .o_mem_write_data(o_mem_write_data), .o_done_flag(o_done_flag),
        .o_done_channel(o_done_channel)
    );
endmodule
`default_nettype wire

### src/dmac_checker.sv
`default_nettype none
module dmac_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [1:0]  o_mem_request,
    input wire logic [31:0] o_mem_write_data,
    input wire logic        o_done_flag,
    input wire logic [2:0]  o_done_channel
);
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid) else $error("missing strobe");
    a_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> (o_mem_request == 2'd0 && !o_done_flag)) else $error("stray result");
    a_wd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_request != 2'd2) |-> (o_mem_write_data == 32'd0)) else $error("write data");
    a_dch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done_flag |-> (o_done_channel == 3'd0)) else $error("done channel");
endmodule

bind dma_controller_three_sync_modes dmac_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_mem_request(o_mem_request),
    .o_mem_write_data(o_mem_write_data), .o_done_flag(o_done_flag),
    .o_done_channel(o_done_channel)
);
`default_nettype wire
